// ===== sv/pcmw_pkg.sv =====
package pcmw_pkg;

  localparam int WAVE_AW = 16;

  typedef enum logic [2:0] {
    OP_REG_WR  = 3'd0,
    OP_REG_RD  = 3'd1,
    OP_WAVE_WR = 3'd2,
    OP_WAVE_RD = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  localparam logic [11:0] REG_VOL     = 12'h000;
  localparam logic [11:0] REG_PAN     = 12'h001;
  localparam logic [11:0] REG_STEP_LO = 12'h002;
  localparam logic [11:0] REG_STEP_HI = 12'h003;
  localparam logic [11:0] REG_LOOP_LO = 12'h004;
  localparam logic [11:0] REG_LOOP_HI = 12'h005;
  localparam logic [11:0] REG_START   = 12'h006;
  localparam logic [11:0] REG_CTRL    = 12'h007;
  localparam logic [11:0] REG_OFF     = 12'h008;
  localparam logic [7:0]  REG_POS_GRP = 8'h01;

  localparam logic [7:0]  LOOP_MARK = 8'hFF;
  localparam logic [16:0] MIX_MID   = 17'h08000;
  localparam logic [16:0] MIX_MAX   = 17'h0FFFF;
  localparam logic [15:0] MIX_FLOOR = 16'h8001;

  typedef struct packed {
    op_e         op;
    logic [11:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WWAIT,
    S_TCHK,
    S_TADV,
    S_TLOOP,
    S_TMUL1,
    S_TMUL2,
    S_TACC,
    S_TNEXT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic clr;
    logic latch;
    logic exec;
    logic wave_rd;
    logic take_wave;
    logic tick_start;
    logic rd_sample;
    logic adv;
    logic take_loop;
    logic mul1;
    logic mul2;
    logic acc;
    logic next_ch;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_e  op;
    logic audible;
    logic muted;
    logic smp_ff;
    logic ch_last;
  } stat_t;

endpackage

// ===== sv/pcmw_ctrl.sv =====
module pcmw_ctrl import pcmw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_e state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_TCHK;
          end
          OP_WAVE_RD: begin
            cmd.wave_rd = 1'b1;
            state_next  = S_WWAIT;
          end
          default: begin
            cmd.exec   = 1'b1;
            state_next = S_FINISH;
          end
        endcase
      end
      S_WWAIT: begin
        cmd.take_wave = 1'b1;
        state_next    = S_FINISH;
      end
      S_TCHK: begin
        if (stat.audible) begin
          cmd.rd_sample = 1'b1;
          state_next    = S_TADV;
        end else begin
          state_next = S_TNEXT;
        end
      end
      S_TADV: begin
        cmd.adv = 1'b1;
        if (stat.smp_ff) state_next = S_TLOOP;
        else if (stat.muted) state_next = S_TNEXT;
        else state_next = S_TMUL1;
      end
      S_TLOOP: begin
        cmd.take_loop = 1'b1;
        state_next    = stat.muted ? S_TNEXT : S_TMUL1;
      end
      S_TMUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_TMUL2;
      end
      S_TMUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.acc    = 1'b1;
        state_next = S_TNEXT;
      end
      S_TNEXT: begin
        if (stat.ch_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.next_ch = 1'b1;
          state_next  = S_TCHK;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word did not start execution");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while full");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish");

endmodule

// ===== sv/pcmw_datapath.sv =====
module pcmw_datapath import pcmw_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_word_t out_word
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [7:0]              mute_mask;
  logic [NUM_CHANNELS-1:0] ch_off;
  logic [7:0]              vol     [NUM_CHANNELS];
  logic [3:0]              pan_l   [NUM_CHANNELS];
  logic [3:0]              pan_r   [NUM_CHANNELS];
  logic [15:0]             step    [NUM_CHANNELS];
  logic [15:0]             loop_pt [NUM_CHANNELS];
  logic [7:0]              start   [NUM_CHANNELS];
  logic [26:0]             pos     [NUM_CHANNELS];
  logic                    sound_on;
  logic [3:0]              bank;
  logic [2:0]              chsel;

  logic [7:0]  mem [2**WAVE_AW];
  logic [7:0]  mem_q;
  logic [WAVE_AW-1:0] clr_cnt;

  in_word_t    item;
  logic [CW-1:0] ch;
  logic [7:0]  smp;
  logic [14:0] prod1;
  logic [13:0] scl_l, scl_r;
  logic [16:0] mix_l, mix_r;
  logic [7:0]  res_data;

  logic [2:0]  rd_sel;
  logic        sel_ok;
  logic [CW-1:0] idx;
  logic        chsel_ok;
  logic [CW-1:0] widx;
  logic        is_pos;
  logic [7:0]  rd_val;

  logic        mem_we;
  logic [WAVE_AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic        wr;
  logic        rl_en, rl_snd;
  logic [NUM_CHANNELS-1:0] rl_off;
  logic        wr_start;

  assign is_pos   = (item.address[11:4] == REG_POS_GRP);
  assign rd_sel   = (cmd.exec && is_pos) ? item.address[3:1] : (cmd.exec ? chsel : 3'(ch));
  assign sel_ok   = ({1'b0, rd_sel} < 4'(NUM_CHANNELS));
  assign idx      = rd_sel[CW-1:0];
  assign chsel_ok = ({1'b0, chsel} < 4'(NUM_CHANNELS));
  assign widx     = chsel[CW-1:0];

  assign wr       = cmd.exec && (item.op == OP_REG_WR);
  assign wr_start = wr && chsel_ok && (item.address == REG_START);

  always_comb begin
    rl_en  = 1'b0;
    rl_snd = sound_on;
    rl_off = ch_off;
    if (wr && item.address == REG_CTRL) begin
      rl_en  = 1'b1;
      rl_snd = item.data[7];
    end
    if (wr && item.address == REG_OFF) begin
      rl_en  = 1'b1;
      rl_off = item.data[NUM_CHANNELS-1:0];
    end
  end

  always_comb begin
    rd_val = '0;
    if (item.address == REG_OFF) begin
      rd_val = 8'(ch_off);
    end else if (is_pos) begin
      if (sel_ok) rd_val = item.address[0] ? pos[idx][26:19] : pos[idx][18:11];
    end else if (sel_ok) begin
      case (item.address)
        REG_VOL:     rd_val = vol[idx];
        REG_PAN:     rd_val = {pan_r[idx], pan_l[idx]};
        REG_STEP_LO: rd_val = step[idx][7:0];
        REG_STEP_HI: rd_val = step[idx][15:8];
        REG_LOOP_LO: rd_val = loop_pt[idx][7:0];
        REG_LOOP_HI: rd_val = loop_pt[idx][15:8];
        REG_START:   rd_val = start[idx];
        default:     rd_val = '0;
      endcase
    end
  end

  // The clearing pass owns the write port until it finishes.
  always_comb begin
    mem_we = cmd.clr || (cmd.exec && item.op == OP_WAVE_WR);
    mem_wa = cmd.clr ? clr_cnt : {bank, item.address};
    mem_wd = cmd.clr ? 8'h00 : item.data;
    if (cmd.rd_sample)  mem_ra = pos[idx][26:11];
    else if (cmd.adv)   mem_ra = loop_pt[idx];
    else                mem_ra = {bank, item.address};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_mask <= '0;
      ch_off    <= '1;
      sound_on  <= 1'b0;
      bank      <= '0;
      chsel     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol[i]     <= '0;
        pan_l[i]   <= '0;
        pan_r[i]   <= '0;
        step[i]    <= '0;
        loop_pt[i] <= '0;
        start[i]   <= '0;
        pos[i]     <= '0;
      end
    end else begin
      if (cfg_we) mute_mask <= cfg_wdata;
      if (wr && item.address == REG_CTRL) begin
        sound_on <= item.data[7];
        if (item.data[6]) chsel <= item.data[2:0];
        else bank <= item.data[3:0];
      end
      if (wr && item.address == REG_OFF) ch_off <= item.data[NUM_CHANNELS-1:0];
      if (wr && chsel_ok) begin
        case (item.address)
          REG_VOL:     vol[widx] <= item.data;
          REG_PAN: begin
            pan_l[widx] <= item.data[3:0];
            pan_r[widx] <= item.data[7:4];
          end
          REG_STEP_LO: step[widx][7:0]     <= item.data;
          REG_STEP_HI: step[widx][15:8]    <= item.data;
          REG_LOOP_LO: loop_pt[widx][7:0]  <= item.data;
          REG_LOOP_HI: loop_pt[widx][15:8] <= item.data;
          REG_START:   start[widx]         <= item.data;
          default: ;
        endcase
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (rl_en && !(rl_snd && !rl_off[i])) pos[i] <= {start[i], 19'b0};
        if (wr_start && widx == CW'(i) && !(sound_on && !ch_off[i]))
          pos[i] <= {item.data, 19'b0};
        if (cmd.adv && ch == CW'(i)) begin
          if (mem_q == LOOP_MARK) pos[i] <= {loop_pt[i], 11'b0};
          else pos[i] <= pos[i] + {11'b0, step[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= in_word;
    if (cmd.exec) res_data <= rd_val;
    if (cmd.take_wave) res_data <= mem_q;
    if (cmd.tick_start) ch <= '0;
    else if (cmd.next_ch) ch <= ch + 1'b1;
    if (cmd.adv || cmd.take_loop) smp <= mem_q;
    if (cmd.mul1) prod1 <= smp[6:0] * vol[idx];
    if (cmd.mul2) begin
      scl_l <= 14'((19'(prod1) * 19'(pan_l[idx])) >> 5);
      scl_r <= 14'((19'(prod1) * 19'(pan_r[idx])) >> 5);
    end
  end

  function automatic logic [16:0] mix_add(input logic [16:0] m, input logic [13:0] s,
                                          input logic up);
    logic [16:0] sum;
    sum = m + {3'b0, s};
    if (up) return (sum > MIX_MAX) ? MIX_MAX : sum;
    return ({3'b0, s} > m) ? 17'd0 : m - {3'b0, s};
  endfunction

  function automatic logic [15:0] to_s16(input logic [16:0] t);
    if (t == 17'd0) return MIX_FLOOR;
    return {~t[15], t[14:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      mix_l <= MIX_MID;
      mix_r <= MIX_MID;
    end else if (cmd.acc) begin
      mix_l <= mix_add(mix_l, scl_l, smp[7]);
      mix_r <= mix_add(mix_r, scl_r, smp[7]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word.read_data <= (item.op == OP_REG_RD || item.op == OP_WAVE_RD) ? res_data : 8'h00;
      out_word.left_sample  <= (item.op == OP_TICK) ? to_s16(mix_l) : 16'h0000;
      out_word.right_sample <= (item.op == OP_TICK) ? to_s16(mix_r) : 16'h0000;
    end
  end

  always_comb begin
    stat.clr_last = &clr_cnt;
    stat.op       = item.op;
    stat.audible  = sound_on && !ch_off[idx];
    stat.muted    = mute_mask[3'(ch)];
    stat.smp_ff   = (mem_q == LOOP_MARK);
    stat.ch_last  = (ch == CW'(NUM_CHANNELS - 1));
  end

endmodule

// ===== sv/pcm_wavetable_sound_source.sv =====
// Channel  Signals                       Word
// in       in_valid / in_ready           in_word  (op, address, data)
// out      out_valid / out_ready         out_word (read_data, left_sample, right_sample)
// cfg      cfg_we / cfg_wdata            host mute mask, taken at once
//
// Register and wave writes and register reads pass EXEC then FINISH; wave reads add WWAIT.
// A tick visits TCHK and TNEXT for each channel; an audible one also reads a sample
// on the one wave read port and, unless muted, runs the two-stage volume/pan multiply.
// After reset the wave memory is cleared, one byte a cycle, all 65536 bytes,
// before the first word is accepted. A new word is taken while a result waits
// in the output register; a stalled output holds the next result in place.
module pcm_wavetable_sound_source import pcmw_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  pcmw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcmw_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule
